/* rtl/mdef_pkg.sv */
// shared constants, types and codes of the mash distance edge filter
package mdef_pkg;

  localparam int COUNT_BITS = 20;
  localparam int ID_BITS    = 24;
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int K_W        = 6;
  localparam int SUM_W      = COUNT_BITS + 1;

  localparam logic [Q_W-1:0] Q_ONE        = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] THRESH_RESET = Q_W'(3277);
  localparam logic [K_W-1:0] KMER_RESET   = K_W'(21);

  localparam int IN_W   = ID_BITS * 2 + COUNT_BITS * 3;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = ID_BITS * 2 + Q_W * 2;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // exponent search
  localparam int EXP_W      = 5;
  localparam int NORM_STEPS = 5;
  localparam int NORM_CMP_W = SUM_W + (1 << EXP_W);

  // mantissa division and squaring
  localparam int MANT_BITS  = 30;
  localparam int M_W        = MANT_BITS + 1;
  localparam int DV1_W      = SUM_W * 2;
  localparam int LOG_FRAC   = 32;
  localparam int L24_W      = EXP_W + LOG_FRAC - 8;
  localparam int LN2_W      = 32;
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int PROD_W     = L24_W + LN2_W;

  // rounding division by k
  localparam int RND_SH     = 56 - FRAC_BITS;
  localparam int P_W        = PROD_W + 1;
  localparam int QDIV_STEPS = P_W - RND_SH;
  localparam int DV2_W      = RND_SH + K_W;

  localparam int OFF_D = NORM_STEPS;
  localparam int OFF_S = OFF_D + M_W;
  localparam int OFF_M = OFF_S + LOG_FRAC;
  localparam int OFF_B = OFF_M + 1;
  localparam int OFF_Q = OFF_B + 1;
  localparam int TOT   = OFF_Q + QDIV_STEPS;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = 2;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_KMER   = 1'b1;

  typedef enum logic [1:0] {
    ST_EDGE  = 2'd0,
    ST_ORDER = 2'd1,
    ST_RATIO = 2'd2,
    ST_FAR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_BITS-1:0] from_id;
    logic [ID_BITS-1:0] to_id;
    status_t            status;
    logic               need_log;
    logic [Q_W-1:0]     dfix;
  } pl_t;

  typedef struct packed {
    pl_t              pl;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } q_item_t;

endpackage

/* rtl/mdef_front.sv */
// front end: unpacks a pair and sorts out skips and trivial distances
module mdef_front (
  input  logic [mdef_pkg::IN_TW-1:0] in_tdata,
  output mdef_pkg::q_item_t          item
);

  logic [mdef_pkg::ID_BITS-1:0]    id0, id1;
  logic [mdef_pkg::COUNT_BITS-1:0] c, a, b, lo, hi;
  logic [mdef_pkg::SUM_W-1:0]      total, c2;

  always_comb begin
    id0 = in_tdata[mdef_pkg::ID_BITS-1:0];
    id1 = in_tdata[2*mdef_pkg::ID_BITS-1:mdef_pkg::ID_BITS];
    c   = in_tdata[2*mdef_pkg::ID_BITS+mdef_pkg::COUNT_BITS-1:2*mdef_pkg::ID_BITS];
    a   = in_tdata[2*mdef_pkg::ID_BITS+2*mdef_pkg::COUNT_BITS-1:
                   2*mdef_pkg::ID_BITS+mdef_pkg::COUNT_BITS];
    b   = in_tdata[2*mdef_pkg::ID_BITS+3*mdef_pkg::COUNT_BITS-1:
                   2*mdef_pkg::ID_BITS+2*mdef_pkg::COUNT_BITS];
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    total = mdef_pkg::SUM_W'(a) + mdef_pkg::SUM_W'(b);
    c2    = {c, 1'b0};

    item.pl.from_id  = id0;
    item.pl.to_id    = id1;
    item.pl.status   = mdef_pkg::ST_EDGE;
    item.pl.need_log = 1'b0;
    item.pl.dfix     = '0;
    item.num         = total;
    item.den         = c2;
    if (id0 >= id1) begin
      item.pl.status = mdef_pkg::ST_ORDER;
    end else if ({lo, 1'b0} < mdef_pkg::SUM_W'(hi)) begin
      item.pl.status = mdef_pkg::ST_RATIO;
    end else if (c == '0 || total <= mdef_pkg::SUM_W'(c)) begin
      item.pl.dfix = mdef_pkg::Q_ONE;
    end else if (c2 >= total) begin
      item.pl.dfix = '0;
    end else begin
      item.pl.need_log = 1'b1;
    end
  end

endmodule

/* rtl/mdef_fifo.sv */
// short queue between the front end and the distance pipeline
module mdef_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  mdef_pkg::q_item_t       wdata,
  output logic                    not_full,
  input  logic                    pop,
  output logic                    not_empty,
  output mdef_pkg::q_item_t       rdata
);

  mdef_pkg::q_item_t               mem [mdef_pkg::FIFO_DEPTH];
  logic [mdef_pkg::FPTR_W-1:0]     wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [mdef_pkg::FPTR_W:0]       cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign not_full  = (cnt_r != (mdef_pkg::FPTR_W+1)'(mdef_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem[rptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = wptr_r + mdef_pkg::FPTR_W'(do_push);
    rptr_nxt = rptr_r + mdef_pkg::FPTR_W'(do_pop);
    cnt_nxt  = cnt_r + (mdef_pkg::FPTR_W+1)'(do_push) - (mdef_pkg::FPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (mdef_pkg::FPTR_W+1)'(mdef_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !do_pop)
    else $error("pop from empty queue");

endmodule

/* rtl/mdef_back.sv */
// distance pipeline: exponent search, mantissa divide, log squaring, scale, round, filter
module mdef_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fifo_valid,
  input  mdef_pkg::q_item_t            fifo_item,
  output logic                         fifo_pop,
  input  logic [mdef_pkg::Q_W-1:0]     thresh,
  input  logic [mdef_pkg::K_W-1:0]     kmer,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mdef_pkg::status_t            out_status,
  output logic [mdef_pkg::ID_BITS-1:0] out_from,
  output logic [mdef_pkg::ID_BITS-1:0] out_to,
  output logic [mdef_pkg::Q_W-1:0]     out_dist,
  output logic [mdef_pkg::Q_W-1:0]     out_weight
);

  localparam int TOT = mdef_pkg::TOT;

  logic                 en;
  logic                 vld_r [TOT];
  mdef_pkg::pl_t        pl_r  [TOT];

  logic [mdef_pkg::SUM_W-1:0]  nnum_r [mdef_pkg::NORM_STEPS];
  logic [mdef_pkg::SUM_W-1:0]  nden_r [mdef_pkg::NORM_STEPS];
  logic [mdef_pkg::EXP_W-1:0]  ne_r   [mdef_pkg::NORM_STEPS];

  logic [mdef_pkg::DV1_W-1:0]  drem_r [mdef_pkg::M_W];
  logic [mdef_pkg::DV1_W-1:0]  ddvs_r [mdef_pkg::M_W];
  logic [mdef_pkg::M_W-1:0]    dq_r   [mdef_pkg::M_W];
  logic [mdef_pkg::EXP_W-1:0]  de_r   [mdef_pkg::M_W];

  logic [mdef_pkg::M_W-1:0]      sm_r [mdef_pkg::LOG_FRAC];
  logic [mdef_pkg::LOG_FRAC-1:0] sf_r [mdef_pkg::LOG_FRAC];
  logic [mdef_pkg::EXP_W-1:0]    se_r [mdef_pkg::LOG_FRAC];

  logic [mdef_pkg::PROD_W-1:0] prod_r;
  logic [mdef_pkg::P_W-1:0]    p_r;
  logic [mdef_pkg::K_W-1:0]    keff;
  logic [mdef_pkg::DV2_W-1:0]  dvs2;

  logic [mdef_pkg::DV2_W-1:0]      qrem_r [mdef_pkg::QDIV_STEPS];
  logic [mdef_pkg::QDIV_STEPS-1:0] qlo_r  [mdef_pkg::QDIV_STEPS];
  logic [mdef_pkg::QDIV_STEPS-1:0] qq_r   [mdef_pkg::QDIV_STEPS];

  logic                        out_valid_r;
  mdef_pkg::status_t           status_r, status_nxt;
  logic [mdef_pkg::ID_BITS-1:0] from_r, to_r;
  logic [mdef_pkg::Q_W-1:0]    dist_r, dist_nxt, weight_r, weight_nxt;
  logic [mdef_pkg::Q_W-1:0]    dlog;

  assign en       = !out_valid_r || out_ready;
  assign fifo_pop = en;
  assign keff     = (kmer == '0) ? mdef_pkg::K_W'(1) : kmer;
  assign dvs2     = {keff, {mdef_pkg::RND_SH{1'b0}}};

  // valid and payload shift line
  genvar i;
  generate
    for (i = 0; i < TOT; i++) begin : g_pl
      if (i == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[i] <= 1'b0;
          end else if (en) begin
            vld_r[i] <= fifo_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            pl_r[i] <= fifo_item.pl;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[i] <= 1'b0;
          end else if (en) begin
            vld_r[i] <= vld_r[i-1];
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            pl_r[i] <= pl_r[i-1];
          end
        end
      end
    end
  endgenerate

  // exponent search, binary steps from the largest shift down
  generate
    for (i = 0; i < mdef_pkg::NORM_STEPS; i++) begin : g_norm
      localparam int SH = 1 << (mdef_pkg::NORM_STEPS - 1 - i);
      logic [mdef_pkg::SUM_W-1:0] num_in, den_in;
      logic [mdef_pkg::EXP_W-1:0] e_in, cand;
      logic                       fit;
      if (i == 0) begin : g_src0
        assign num_in = fifo_item.num;
        assign den_in = fifo_item.den;
        assign e_in   = '0;
      end else begin : g_srcn
        assign num_in = nnum_r[i-1];
        assign den_in = nden_r[i-1];
        assign e_in   = ne_r[i-1];
      end
      always_comb begin
        cand = e_in + mdef_pkg::EXP_W'(SH);
        fit  = ((mdef_pkg::NORM_CMP_W'(den_in) << cand) <= mdef_pkg::NORM_CMP_W'(num_in));
      end
      always_ff @(posedge clk) begin
        if (en) begin
          nnum_r[i] <= num_in;
          nden_r[i] <= den_in;
          ne_r[i]   <= fit ? cand : e_in;
        end
      end
    end
  endgenerate

  // restoring divide for the mantissa num / (den << e), one bit per stage
  generate
    for (i = 0; i < mdef_pkg::M_W; i++) begin : g_div1
      logic [mdef_pkg::DV1_W-1:0] rem_in, dvs_in;
      logic [mdef_pkg::M_W-1:0]   q_in;
      logic [mdef_pkg::EXP_W-1:0] e_in;
      logic                       bit_in;
      logic [mdef_pkg::DV1_W:0]   t;
      logic                       ge;
      if (i == 0) begin : g_src0
        assign rem_in = mdef_pkg::DV1_W'(nnum_r[mdef_pkg::NORM_STEPS-1] >> 1);
        assign dvs_in = mdef_pkg::DV1_W'(mdef_pkg::DV1_W'(nden_r[mdef_pkg::NORM_STEPS-1])
                                         << ne_r[mdef_pkg::NORM_STEPS-1]);
        assign q_in   = '0;
        assign e_in   = ne_r[mdef_pkg::NORM_STEPS-1];
        assign bit_in = nnum_r[mdef_pkg::NORM_STEPS-1][0];
      end else begin : g_srcn
        assign rem_in = drem_r[i-1];
        assign dvs_in = ddvs_r[i-1];
        assign q_in   = dq_r[i-1];
        assign e_in   = de_r[i-1];
        assign bit_in = 1'b0;
      end
      always_comb begin
        t  = {rem_in, bit_in};
        ge = (t >= (mdef_pkg::DV1_W+1)'(dvs_in));
      end
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[i] <= ge ? mdef_pkg::DV1_W'(t - (mdef_pkg::DV1_W+1)'(dvs_in))
                          : mdef_pkg::DV1_W'(t);
          ddvs_r[i] <= dvs_in;
          dq_r[i]   <= {q_in[mdef_pkg::M_W-2:0], ge};
          de_r[i]   <= e_in;
        end
      end
    end
  endgenerate

  // fractional log bits by repeated squaring of the mantissa
  generate
    for (i = 0; i < mdef_pkg::LOG_FRAC; i++) begin : g_sq
      logic [mdef_pkg::M_W-1:0]      m_in;
      logic [mdef_pkg::LOG_FRAC-1:0] f_in;
      logic [mdef_pkg::EXP_W-1:0]    e_in;
      logic [2*mdef_pkg::M_W-1:0]    sq;
      logic [mdef_pkg::M_W:0]        t;
      if (i == 0) begin : g_src0
        assign m_in = dq_r[mdef_pkg::M_W-1];
        assign f_in = '0;
        assign e_in = de_r[mdef_pkg::M_W-1];
      end else begin : g_srcn
        assign m_in = sm_r[i-1];
        assign f_in = sf_r[i-1];
        assign e_in = se_r[i-1];
      end
      always_comb begin
        sq = (2*mdef_pkg::M_W)'(m_in) * (2*mdef_pkg::M_W)'(m_in);
        t  = sq[2*mdef_pkg::M_W-1:mdef_pkg::MANT_BITS];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sm_r[i] <= t[mdef_pkg::M_W] ? t[mdef_pkg::M_W:1] : t[mdef_pkg::M_W-1:0];
          sf_r[i] <= {f_in[mdef_pkg::LOG_FRAC-2:0], t[mdef_pkg::M_W]};
          se_r[i] <= e_in;
        end
      end
    end
  endgenerate

  // scale by ln2, then add the rounding bias k/2 ahead of the divide
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mdef_pkg::PROD_W'({se_r[mdef_pkg::LOG_FRAC-1],
                                   sf_r[mdef_pkg::LOG_FRAC-1][mdef_pkg::LOG_FRAC-1:8]})
              * mdef_pkg::PROD_W'(mdef_pkg::LN2_Q32);
      p_r    <= mdef_pkg::P_W'(prod_r)
              + (mdef_pkg::P_W'(keff) << (mdef_pkg::RND_SH - 1));
    end
  end

  // restoring divide by (k << 40)
  generate
    for (i = 0; i < mdef_pkg::QDIV_STEPS; i++) begin : g_div2
      logic [mdef_pkg::DV2_W-1:0]      rem_in;
      logic [mdef_pkg::QDIV_STEPS-1:0] lo_in, q_in;
      logic [mdef_pkg::DV2_W:0]        t;
      logic                            ge;
      if (i == 0) begin : g_src0
        assign rem_in = mdef_pkg::DV2_W'(p_r[mdef_pkg::P_W-1:mdef_pkg::QDIV_STEPS]);
        assign lo_in  = p_r[mdef_pkg::QDIV_STEPS-1:0];
        assign q_in   = '0;
      end else begin : g_srcn
        assign rem_in = qrem_r[i-1];
        assign lo_in  = qlo_r[i-1];
        assign q_in   = qq_r[i-1];
      end
      always_comb begin
        t  = {rem_in, lo_in[mdef_pkg::QDIV_STEPS-1]};
        ge = (t >= (mdef_pkg::DV2_W+1)'(dvs2));
      end
      always_ff @(posedge clk) begin
        if (en) begin
          qrem_r[i] <= ge ? mdef_pkg::DV2_W'(t - (mdef_pkg::DV2_W+1)'(dvs2))
                          : mdef_pkg::DV2_W'(t);
          qlo_r[i]  <= {lo_in[mdef_pkg::QDIV_STEPS-2:0], 1'b0};
          qq_r[i]   <= {q_in[mdef_pkg::QDIV_STEPS-2:0], ge};
        end
      end
    end
  endgenerate

  // clamp, threshold and result register
  always_comb begin
    if (qq_r[mdef_pkg::QDIV_STEPS-1] > mdef_pkg::QDIV_STEPS'(mdef_pkg::Q_ONE)) begin
      dlog = mdef_pkg::Q_ONE;
    end else begin
      dlog = qq_r[mdef_pkg::QDIV_STEPS-1][mdef_pkg::Q_W-1:0];
    end
    status_nxt = pl_r[TOT-1].status;
    dist_nxt   = '0;
    weight_nxt = '0;
    if (pl_r[TOT-1].status == mdef_pkg::ST_EDGE) begin
      dist_nxt = pl_r[TOT-1].need_log ? dlog : pl_r[TOT-1].dfix;
      if (dist_nxt < thresh) begin
        weight_nxt = mdef_pkg::Q_ONE - dist_nxt;
      end else begin
        status_nxt = mdef_pkg::ST_FAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      from_r   <= pl_r[TOT-1].from_id;
      to_r     <= pl_r[TOT-1].to_id;
      dist_r   <= dist_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_from   = from_r;
  assign out_to     = to_r;
  assign out_dist   = dist_r;
  assign out_weight = weight_r;

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == mdef_pkg::ST_ORDER || status_r == mdef_pkg::ST_RATIO)
    |-> dist_r == '0 && weight_r == '0)
    else $error("skipped pair carries a distance");
  a_edge_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == mdef_pkg::ST_EDGE |-> dist_r + weight_r == mdef_pkg::Q_ONE)
    else $error("edge weight does not match distance");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> dist_r <= mdef_pkg::Q_ONE)
    else $error("distance above one");

endmodule

/* rtl/mash_distance_edge_filter.sv */
// top level of the mash distance edge filter: config registers, front end, queue, pipeline
//
// channel  dir  handshake                fields
// in_      in   in_tvalid/in_tready      tdata: first_id, second_id, shared_count, size_a, size_b
// out_     out  out_tvalid/out_tready    tdata: from_id, to_id, distance, weight; tuser: status
// cfg_     in   cfg_valid/cfg_ready      cfg_index 0 threshold, 1 k-mer length; cfg_data
//
// one pair per cycle sustained while out_tready stays high; from acceptance to a valid result a pair passes through
// five exponent search steps, 31 mantissa divide steps, 32 squaring multiplies,
// the ln2 multiply, the rounding add and 22 steps of the divide by k, then the result register.
// synchronous active-low reset empties the queue and the pipeline and restores the registers.
// a stalled result freezes the whole pipeline; the queue keeps taking pairs until it fills.
module mash_distance_edge_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // first_id, second_id, shared_count, size_a, size_b, zero pad
  input  logic [mdef_pkg::IN_TW-1:0]    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // from_id, to_id, distance, weight, zero pad
  output logic [mdef_pkg::OUT_TW-1:0]   out_tdata,
  // status
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [mdef_pkg::Q_W-1:0]      cfg_data
);

  logic [mdef_pkg::Q_W-1:0]      thresh_r;
  logic [mdef_pkg::K_W-1:0]      kmer_r;
  mdef_pkg::q_item_t             f_item, q_item;
  logic                          q_valid, q_pop;
  mdef_pkg::status_t             o_status;
  logic [mdef_pkg::ID_BITS-1:0]  o_from, o_to;
  logic [mdef_pkg::Q_W-1:0]      o_dist, o_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= mdef_pkg::THRESH_RESET;
      kmer_r   <= mdef_pkg::KMER_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mdef_pkg::REG_THRESH) begin
        thresh_r <= cfg_data;
      end else if (cfg_index == mdef_pkg::REG_KMER) begin
        kmer_r <= cfg_data[mdef_pkg::K_W-1:0];
      end
    end
  end

  mdef_front u_front (
    .in_tdata (in_tdata),
    .item     (f_item)
  );

  mdef_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .wdata     (f_item),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_item)
  );

  mdef_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (q_valid),
    .fifo_item  (q_item),
    .fifo_pop   (q_pop),
    .thresh     (thresh_r),
    .kmer       (kmer_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (o_status),
    .out_from   (o_from),
    .out_to     (o_to),
    .out_dist   (o_dist),
    .out_weight (o_weight)
  );

  assign out_tuser = o_status;
  assign out_tdata = mdef_pkg::OUT_TW'({o_weight, o_dist, o_to, o_from});

endmodule

/* bench/testbench.sv */
// self-checking testbench of the mash distance edge filter: directed, random and stall tests
module testbench;

  typedef struct packed {
    mdef_pkg::status_t            status;
    logic [mdef_pkg::ID_BITS-1:0] from_id;
    logic [mdef_pkg::ID_BITS-1:0] to_id;
    logic [mdef_pkg::Q_W-1:0]     distance;
    logic [mdef_pkg::Q_W-1:0]     weight;
  } edge_res_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [mdef_pkg::IN_TW-1:0]    in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [mdef_pkg::OUT_TW-1:0]   out_tdata;
  logic [1:0]                    out_tuser;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic                          cfg_index;
  logic [mdef_pkg::Q_W-1:0]      cfg_data;

  logic [mdef_pkg::Q_W-1:0]      cur_thresh;
  logic [5:0]                    cur_kmer;
  edge_res_t                     pending_edges[$];
  int                            mismatches;
  int                            send_idle_pct;
  int                            recv_idle_pct;
  int                            hold_cycles;

  mash_distance_edge_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] log2_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = 0;
    while ((den << (e + 1)) <= num) e++;
    m = (num << mdef_pkg::MANT_BITS) / (den << e);
    for (int i = 0; i < mdef_pkg::LOG_FRAC; i++) begin
      m = (m * m) >> mdef_pkg::MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << mdef_pkg::MANT_BITS)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (e << mdef_pkg::LOG_FRAC) | frac;
  endfunction

  function automatic logic [mdef_pkg::Q_W-1:0] pair_distance(logic [63:0] c, logic [63:0] a,
                                                             logic [63:0] b, logic [63:0] k);
    logic [63:0] total;
    logic [63:0] prod;
    logic [63:0] d;
    total = a + b;
    if (c == 0 || total <= c) return mdef_pkg::Q_ONE;
    if (2 * c >= total) return '0;
    if (k == 0) k = 1;
    prod = (log2_ratio(total, 2 * c) >> 8) * 64'(mdef_pkg::LN2_Q32);
    d = (prod / k + (64'd1 << (55 - mdef_pkg::FRAC_BITS))) >> (56 - mdef_pkg::FRAC_BITS);
    if (d > 64'(mdef_pkg::Q_ONE)) d = 64'(mdef_pkg::Q_ONE);
    return d[mdef_pkg::Q_W-1:0];
  endfunction

  function automatic edge_res_t filter_pair(logic [mdef_pkg::IN_TW-1:0] d);
    edge_res_t r;
    logic [mdef_pkg::COUNT_BITS-1:0] c, a, b, lo, hi;
    r.from_id  = d[23:0];
    r.to_id    = d[47:24];
    c          = d[67:48];
    a          = d[87:68];
    b          = d[107:88];
    lo         = a < b ? a : b;
    hi         = a < b ? b : a;
    r.distance = '0;
    r.weight   = '0;
    if (r.from_id >= r.to_id) r.status = mdef_pkg::ST_ORDER;
    else if (2 * 64'(lo) < 64'(hi)) r.status = mdef_pkg::ST_RATIO;
    else begin
      r.distance = pair_distance(c, a, b, cur_kmer);
      if (r.distance < cur_thresh) begin
        r.status = mdef_pkg::ST_EDGE;
        r.weight = mdef_pkg::Q_ONE - r.distance;
      end else r.status = mdef_pkg::ST_FAR;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    edge_res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = mdef_pkg::status_t'(out_tuser);
      got.from_id  = out_tdata[23:0];
      got.to_id    = out_tdata[47:24];
      got.distance = out_tdata[64:48];
      got.weight   = out_tdata[81:65];
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_edges.pop_back();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // receiver ready with random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pair(logic [23:0] id0, logic [23:0] id1, logic [19:0] c,
                           logic [19:0] a, logic [19:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a, c, id1, id0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_edges.push_front(filter_pair({4'b0, b, a, c, id1, id0}));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [mdef_pkg::Q_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mdef_pkg::REG_THRESH) cur_thresh = val;
    else cur_kmer = val[5:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_pair;
    logic [19:0] a, b, c, lo;
    logic [23:0] id0, id1;
    int kind;
    kind = $urandom_range(99);
    id0  = 24'($urandom);
    id1  = 24'($urandom);
    if (kind < 80 && id0 >= id1) {id0, id1} = {id1, id0};
    if (kind < 80 && id0 == id1) id1 = id0 + 24'd1;
    a = (kind < 50) ? 20'($urandom_range(4096, 1)) : 20'($urandom_range(20'hfffff, 1));
    b = (kind < 70) ? 20'($urandom_range(2 * a > 20'hfffff ? 20'hfffff : 2 * a, (a + 1) / 2))
                    : 20'($urandom);
    lo = a < b ? a : b;
    if (kind < 40) c = 20'(lo - $urandom_range(lo / 8));
    else if (kind < 90) c = 20'($urandom_range(lo));
    else c = 20'($urandom);
    if (id0 == 24'hffffff && kind < 80) id0 = id1 - 24'd1;
    send_pair(id0, id1, c, a, b);
  endtask

  task automatic test_directed;
    send_pair(24'd0, 24'hffffff, 20'd1000, 20'd1000, 20'd1000);
    send_pair(24'hffffff, 24'hffffff, 20'd5, 20'd10, 20'd10);
    send_pair(24'd7, 24'd3, 20'd5, 20'd10, 20'd10);
    send_pair(24'd1, 24'd2, 20'd5, 20'd10, 20'd21);
    send_pair(24'd1, 24'd2, 20'd5, 20'd10, 20'd20);
    send_pair(24'd1, 24'd2, 20'd0, 20'd10, 20'd10);
    send_pair(24'd1, 24'd2, 20'd0, 20'd0, 20'd0);
    send_pair(24'd1, 24'd2, 20'd3, 20'd0, 20'd0);
    send_pair(24'd1, 24'd2, 20'd0, 20'd0, 20'd7);
    send_pair(24'd1, 24'd2, 20'hfffff, 20'hfffff, 20'hfffff);
    send_pair(24'd1, 24'd2, 20'd1, 20'hfffff, 20'hfffff);
    send_pair(24'd1, 24'd2, 20'd1, 20'd1, 20'd1);
    send_pair(24'd1, 24'd2, 20'd950, 20'd1000, 20'd1000);
    send_pair(24'd1, 24'd2, 20'd999, 20'd1000, 20'd1000);
    send_pair(24'd1, 24'd2, 20'd1, 20'd2, 20'd1);
    send_pair(24'h123456, 24'h654321, 20'd900, 20'd1000, 20'd1500);
    send_pair(24'd1, 24'd2, 20'hfffff, 20'd1, 20'd1);
    send_pair(24'haaaaaa, 24'hd55555, 20'h55555, 20'haaaaa, 20'haaaaa);
  endtask

  task automatic test_random(int n);
    repeat (n) random_pair();
  endtask

  task automatic test_backpressure;
    hold_cycles = 400;
    repeat (140) random_pair();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = mdef_pkg::REG_THRESH;
    cfg_data = '0;
    mismatches = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_thresh = mdef_pkg::THRESH_RESET;
    cur_kmer = mdef_pkg::KMER_RESET;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    drain();
    write_reg(mdef_pkg::REG_THRESH, mdef_pkg::Q_ONE);
    write_reg(mdef_pkg::REG_KMER, 6'd1);
    test_directed();
    drain();

    send_idle_pct = 19;
    recv_idle_pct = 77;
    write_reg(mdef_pkg::REG_THRESH, 17'd0);
    write_reg(mdef_pkg::REG_KMER, 6'd32);
    test_random(80);
    drain();
    write_reg(mdef_pkg::REG_THRESH, 17'd20000);
    write_reg(mdef_pkg::REG_KMER, 6'd63);
    test_random(170);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 19;
    write_reg(mdef_pkg::REG_THRESH, 17'h1ffff);
    write_reg(mdef_pkg::REG_KMER, 6'd0);
    test_random(120);
    drain();
    write_reg(mdef_pkg::REG_THRESH, 17'd3277);
    write_reg(mdef_pkg::REG_KMER, 6'd21);
    test_random(130);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(mdef_pkg::REG_THRESH, 17'd40000);
    write_reg(mdef_pkg::REG_KMER, 6'd5);
    test_backpressure();
    test_random(110);
    drain();

    if (mismatches == 0 && pending_edges.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
